@@ hw/rtl/tte_pkg.sv @@
// Shared types and constants of the transposition table engine.
// No dependencies; imported by every other file of the block but tte_ram.
package tte_pkg;

	localparam int TABLE_ENTRIES = 65536;	// power of two: index is the low key bits
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int KEY_W = 64;
	localparam int SCORE_W = 32;
	localparam int DEPTH_W = 6;
	localparam int SLOT_DEPTH_W = DEPTH_W + 1;	// signed, holds -1 for an empty slot
	localparam int SQ_W = 6;
	localparam int PROMO_W = 3;
	localparam int MOVE_W = 2 * SQ_W + PROMO_W;
	localparam int KIND_W = 2;
	localparam int BOUND_W = 2;

	localparam logic [KIND_W-1:0] KIND_PROBE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic signed [SCORE_W-1:0] score;
		logic signed [SLOT_DEPTH_W-1:0] depth;
		logic [BOUND_W-1:0] bound;
		logic [MOVE_W-1:0] move;	// promo, to, from (from in the low bits)
	} tte_entry_t;

	localparam int ENTRY_W = $bits(tte_entry_t);

	localparam tte_entry_t ENTRY_RESET = '{
		key: '0,
		score: '0,
		depth: {SLOT_DEPTH_W{1'b1}},
		bound: BOUND_EXACT,
		move: '0
	};

	typedef struct packed {
		logic capture;			// latch request word, issue table read
		logic finish;			// evaluate, write back, load response
		logic wipe_en;			// write reset entry at wipe_addr
		logic [IDX_W-1:0] wipe_addr;
	} tte_cmd_t;

	typedef struct packed {
		logic out_free;			// response register can take a word
	} tte_sts_t;

endpackage

@@ hw/rtl/tte_req_if.sv @@
// Request channel of the transposition table engine: valid/ready plus one item.
// Depends on tte_pkg for field widths.
interface tte_req_if import tte_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0] key;
	logic [DEPTH_W-1:0] depth;
	logic signed [SCORE_W-1:0] alpha;
	logic signed [SCORE_W-1:0] beta;
	logic signed [SCORE_W-1:0] store_score;
	logic [BOUND_W-1:0] bound_kind;
	logic [SQ_W-1:0] move_from;
	logic [SQ_W-1:0] move_to;
	logic [PROMO_W-1:0] move_promo;

	modport source (
		output valid, kind, key, depth, alpha, beta, store_score, bound_kind,
			move_from, move_to, move_promo,
		input ready
	);
	modport sink (
		input valid, kind, key, depth, alpha, beta, store_score, bound_kind,
			move_from, move_to, move_promo,
		output ready
	);
endinterface

@@ hw/rtl/tte_rsp_if.sv @@
// Response channel of the transposition table engine: valid/ready plus one result.
// Depends on tte_pkg for field widths.
interface tte_rsp_if import tte_pkg::*; ();
	logic valid;
	logic ready;
	logic hit;
	logic cutoff;
	logic signed [SCORE_W-1:0] result_score;
	logic signed [SCORE_W-1:0] narrowed_alpha;
	logic signed [SCORE_W-1:0] narrowed_beta;
	logic [SQ_W-1:0] hint_from;
	logic [SQ_W-1:0] hint_to;
	logic [PROMO_W-1:0] hint_promo;
	logic done_res;

	modport source (
		output valid, hit, cutoff, result_score, narrowed_alpha, narrowed_beta,
			hint_from, hint_to, hint_promo, done_res,
		input ready
	);
	modport sink (
		input valid, hit, cutoff, result_score, narrowed_alpha, narrowed_beta,
			hint_from, hint_to, hint_promo, done_res,
		output ready
	);
endinterface

@@ hw/rtl/tte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/tte_ctrl.sv @@
// Controller of the transposition table engine: sequencing of accept, evaluate
// and table wipe. Depends on tte_pkg.
module tte_ctrl import tte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic in_ready,
	input  tte_sts_t sts,
	output tte_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_WIPE,
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] wipe_cnt_q;
	logic ack_q;	// wipe was requested by a clear word and owes a response

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.finish = (state_q == ST_EVAL) && sts.out_free;
		cmd.wipe_en = (state_q == ST_WIPE);
		cmd.wipe_addr = wipe_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			wipe_cnt_q <= '0;
			ack_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_kind == KIND_CLEAR) begin
							state_q <= ST_WIPE;
							wipe_cnt_q <= '0;
							ack_q <= 1'b1;
						end else begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WIPE: begin
					wipe_cnt_q <= wipe_cnt_q + 1'b1;
					if (wipe_cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ack_q ? ST_EVAL : ST_IDLE;
						ack_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/tte_datapath.sv @@
// Datapath of the transposition table engine: request registers, slot table,
// probe/replace evaluation and response register. Depends on tte_pkg, tte_ram,
// tte_req_if and tte_rsp_if.
module tte_datapath import tte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tte_req_if.sink req,
	tte_rsp_if.source rsp,
	input  tte_cmd_t cmd,
	output tte_sts_t sts
);

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0] key_q;
	logic [DEPTH_W-1:0] depth_q;
	logic signed [SCORE_W-1:0] alpha_q;
	logic signed [SCORE_W-1:0] beta_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [BOUND_W-1:0] bound_q;
	logic [MOVE_W-1:0] move_q;

	logic [ENTRY_W-1:0] rd_data;
	tte_entry_t slot;
	tte_entry_t new_entry;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic signed [SLOT_DEPTH_W-1:0] req_depth;
	logic replace;

	logic hit_d;
	logic cut_d;
	logic signed [SCORE_W-1:0] score_d;
	logic signed [SCORE_W-1:0] alpha_d;
	logic signed [SCORE_W-1:0] beta_d;
	logic [MOVE_W-1:0] hint_d;
	logic done_d;

	logic out_valid_q;
	logic hit_q;
	logic cut_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic signed [SCORE_W-1:0] res_alpha_q;
	logic signed [SCORE_W-1:0] res_beta_q;
	logic [MOVE_W-1:0] hint_q;
	logic done_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req.kind;
			key_q <= req.key;
			depth_q <= req.depth;
			alpha_q <= req.alpha;
			beta_q <= req.beta;
			score_q <= req.store_score;
			bound_q <= req.bound_kind;
			move_q <= {req.move_promo, req.move_to, req.move_from};
		end
	end

	assign slot = tte_entry_t'(rd_data);
	assign req_depth = $signed({1'b0, depth_q});
	// empty slots hold depth -1, so any stored depth wins over them
	assign replace = (slot.key == '0) || (req_depth >= slot.depth);

	always_comb begin
		new_entry.key = key_q;
		new_entry.score = score_q;
		new_entry.depth = req_depth;
		new_entry.bound = bound_q;
		new_entry.move = move_q;
	end

	assign wr_en = cmd.wipe_en || (cmd.finish && (kind_q == KIND_STORE) && replace);
	assign wr_addr = cmd.wipe_en ? cmd.wipe_addr : key_q[IDX_W-1:0];
	assign wr_data = cmd.wipe_en ? ENTRY_W'(ENTRY_RESET) : ENTRY_W'(new_entry);

	tte_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_slots (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(cmd.capture),
		.raddr(req.key[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		hit_d = 1'b0;
		cut_d = 1'b0;
		score_d = '0;
		alpha_d = '0;
		beta_d = '0;
		hint_d = '0;
		done_d = 1'b0;
		case (kind_q)
			KIND_PROBE: begin
				alpha_d = alpha_q;
				beta_d = beta_q;
				hit_d = (slot.key == key_q);
				if (hit_d) begin
					score_d = slot.score;
					hint_d = slot.move;
					if (slot.depth >= req_depth) begin
						if (slot.bound == BOUND_EXACT) begin
							cut_d = 1'b1;
						end else begin
							if ((slot.bound == BOUND_LOWER) && (slot.score > alpha_q)) begin
								alpha_d = slot.score;
							end else if ((slot.bound == BOUND_UPPER) && (slot.score < beta_q)) begin
								beta_d = slot.score;
							end
							cut_d = (alpha_d >= beta_d);
						end
					end
				end
			end
			KIND_STORE: begin
				done_d = 1'b1;
			end
			KIND_CLEAR: begin
				done_d = 1'b1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	assign sts.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hit_q <= hit_d;
			cut_q <= cut_d;
			res_score_q <= score_d;
			res_alpha_q <= alpha_d;
			res_beta_q <= beta_d;
			hint_q <= hint_d;
			done_q <= done_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit = hit_q;
	assign rsp.cutoff = cut_q;
	assign rsp.result_score = res_score_q;
	assign rsp.narrowed_alpha = res_alpha_q;
	assign rsp.narrowed_beta = res_beta_q;
	assign rsp.hint_from = hint_q[SQ_W-1:0];
	assign rsp.hint_to = hint_q[2*SQ_W-1:SQ_W];
	assign rsp.hint_promo = hint_q[MOVE_W-1:2*SQ_W];
	assign rsp.done_res = done_q;

endmodule

@@ hw/rtl/transposition_table_engine.sv @@
// Transposition table engine, top level: direct-mapped slot table with probe/store/clear.
// Probe or store: accept registers the request and reads the table, then evaluate and write
// back load the response word, held off while it is not taken; no new accept until then.
// Clear: every slot is wiped, one slot written per cycle, then the done word is loaded.
// After arst_n releases, a wipe of every slot of the slot RAM runs with ready low.
// Depends on tte_pkg, tte_req_if, tte_rsp_if, tte_ctrl, tte_datapath.
module transposition_table_engine import tte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tte_req_if.sink req,
	tte_rsp_if.source rsp
);

	tte_cmd_t cmd;
	tte_sts_t sts;
	logic ctl_ready;

	assign req.ready = ctl_ready;

	tte_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_kind(req.kind),
		.in_ready(ctl_ready),
		.sts(sts),
		.cmd(cmd)
	);

	tte_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cmd(cmd),
		.sts(sts)
	);

`ifndef SYNTH
	// a table read and a write-back or wipe never share a cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.finish && !cmd.wipe_en)
		else $error("capture overlaps finish or wipe");

	// a response word only appears after an evaluate step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.finish))
		else $error("response without evaluate");

	// store/clear acknowledgements never report a hit
	a_done_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.done_res |-> !rsp.hit && !rsp.cutoff)
		else $error("done word carries probe flags");

	// no request is taken while the table is being wiped
	a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wipe_en |-> !req.ready)
		else $error("ready during wipe");
`endif

endmodule
